FILE: hw/rtl/rc4_pkg.sv
// Shared types and constants for the RC4 keystream cipher.
// No dependencies; imported by rc4_perm_ram and rc4_keystream_cipher.
`default_nettype none

package rc4_pkg;

  localparam int unsigned TABLE_SIZE = 256;
  localparam int unsigned ADDR_W     = 8;
  localparam int unsigned KEY_BYTES  = 16;
  localparam int unsigned KEY_IDX_W  = 4;
  localparam int unsigned KEY_LEN_W  = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [ADDR_W-1:0]    LAST_IDX    = ADDR_W'(TABLE_SIZE - 1);
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_MAX = KEY_LEN_W'(KEY_BYTES);
  localparam logic [KEY_IDX_W-1:0] KEY_IDX_MAX = KEY_IDX_W'(KEY_BYTES - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LOW    = 2'd0,
    CFG_KEY_HIGH   = 2'd1,
    CFG_KEY_LENGTH = 2'd2
  } rc4_cfg_e;

  typedef enum logic {
    OP_REKEY = 1'b0,
    OP_CRYPT = 1'b1
  } rc4_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_D_RDJ,
    ST_D_WRI,
    ST_D_WRJ,
    ST_D_OUT,
    ST_K_CLR,
    ST_K_RD,
    ST_K_J,
    ST_K_WK,
    ST_K_WJ
  } rc4_state_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
    logic       end_of_message;
  } rc4_in_t;

  typedef struct packed {
    logic [7:0] result_byte;
    logic       last_of_message;
  } rc4_out_t;

  typedef struct packed {
    logic              clear;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } rc4_ram_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rc4_perm_ram.sv
// Permutation table: 256 x 8 memory, one write and one registered read per cycle.
// Per-entry valid bits make an unwritten entry read as its own address (identity).
// Depends on rc4_pkg.
`default_nettype none

module rc4_perm_ram import rc4_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire rc4_ram_ctrl_t ctrl_i,
  output logic [7:0]         rdata_o
);

  logic [7:0]            mem_q [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] vld_q;
  logic [7:0]            rdata_q;
  logic [ADDR_W-1:0]     raddr_q;
  logic                  rvld_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mem_q[ctrl_i.waddr] <= ctrl_i.wdata;
    end
    if (ctrl_i.re) begin
      rdata_q <= mem_q[ctrl_i.raddr];
      raddr_q <= ctrl_i.raddr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (ctrl_i.clear) begin
        vld_q <= '0;
      end else if (ctrl_i.we) begin
        vld_q[ctrl_i.waddr] <= 1'b1;
      end
      if (ctrl_i.re) begin
        rvld_q <= vld_q[ctrl_i.raddr];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : raddr_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rc4_keystream_cipher.sv
// RC4 keystream cipher top level: handshake, configuration registers, sequencer.
// Depends on rc4_pkg and rc4_perm_ram.
`default_nettype none

// RC4 cipher over a 256-byte permutation table with one write and one registered read
// port and one shared 8-bit adder. A data transaction (operation = 1) holds the
// sequencer from the accepting cycle on: read S[i], read S[j], write S[i],
// write S[j] while reading S[S[i]+S[j]], then load the result register. The order of
// table accesses through the one write and one read port sets these steps, and no
// data transaction is accepted before the last one is through them; an untaken result
// still in the output register stretches the last step. A rekey transaction
// (operation = 0) holds it from the accepting cycle through a step to restore the
// identity table (valid bits cleared at once, no sweep), one to read S[0], then the
// read-j, write-S[i] and write-S[j] states of each of the 256 swap steps, and gives no result.
// in_ready_o is high only while the sequencer is idle; a finished result waits in
// its output register without blocking the next transaction. Key registers
// must be written only while no transaction is in flight; the block does not enforce it.
module rc4_keystream_cipher import rc4_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire rc4_in_t               in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output rc4_out_t                   out_data_o
);

  logic [CFG_DATA_W-1:0] key_low_q, key_high_q;
  logic [KEY_LEN_W-1:0]  key_len_q;

  rc4_state_e        state_q, state_d;
  logic [ADDR_W-1:0] i_q, i_d, j_q, j_d;
  logic [7:0]        s_q, s_d, sj_q, sj_d;
  logic              byp_q, byp_d;
  logic [KEY_IDX_W-1:0] kidx_q, kidx_d, len_m1;
  rc4_in_t           in_q, in_d;
  rc4_out_t          out_q, out_d;
  logic              out_valid_q, out_valid_d;

  rc4_ram_ctrl_t ram_ctrl;
  logic [7:0]    ram_rdata, fwd_rd, key_byte;
  logic [7:0]    add_a, add_b, add_c, sum;
  logic [2*CFG_DATA_W-1:0] key_vec;

  rc4_perm_ram u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ram_ctrl),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      key_len_q  <= KEY_LEN_MAX;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_KEY_LOW:    key_low_q  <= cfg_wdata_i;
        CFG_KEY_HIGH:   key_high_q <= cfg_wdata_i;
        CFG_KEY_LENGTH: key_len_q  <= cfg_wdata_i[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // zero length acts as one byte, anything above the maximum saturates
  always_comb begin
    priority if (key_len_q == '0) begin
      len_m1 = '0;
    end else if (key_len_q > KEY_LEN_MAX) begin
      len_m1 = KEY_IDX_MAX;
    end else begin
      len_m1 = KEY_IDX_W'(key_len_q - KEY_LEN_W'(1));
    end
  end

  assign key_vec  = {key_high_q, key_low_q};
  assign key_byte = key_vec[{kidx_q, 3'b000} +: 8];

  // read data with forwarding of a write that hit the address read in the same cycle
  assign fwd_rd = byp_q ? s_q : ram_rdata;

  // shared adder
  always_comb begin
    add_a = '0;
    add_b = '0;
    add_c = '0;
    unique case (state_q)
      ST_IDLE, ST_K_WJ: begin
        add_a = i_q;
        add_b = 8'd1;
      end
      ST_D_RDJ: begin
        add_a = j_q;
        add_b = ram_rdata;
      end
      ST_D_WRJ: begin
        add_a = s_q;
        add_b = sj_q;
      end
      ST_K_J: begin
        add_a = j_q;
        add_b = fwd_rd;
        add_c = key_byte;
      end
      default: ;
    endcase
  end

  assign sum = add_a + add_b + add_c;

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    s_d         = s_q;
    sj_d        = sj_q;
    byp_d       = byp_q;
    kidx_d      = kidx_q;
    in_d        = in_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_ctrl    = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        ram_ctrl.re    = 1'b1;
        ram_ctrl.raddr = sum;
        if (in_valid_i) begin
          in_d = in_data_i;
          if (in_data_i.operation == OP_REKEY) begin
            state_d = ST_K_CLR;
          end else begin
            i_d     = sum;
            state_d = ST_D_RDJ;
          end
        end
      end
      ST_D_RDJ: begin
        s_d            = ram_rdata;
        j_d            = sum;
        ram_ctrl.re    = 1'b1;
        ram_ctrl.raddr = sum;
        state_d        = ST_D_WRI;
      end
      ST_D_WRI: begin
        sj_d           = ram_rdata;
        ram_ctrl.we    = 1'b1;
        ram_ctrl.waddr = i_q;
        ram_ctrl.wdata = ram_rdata;
        state_d        = ST_D_WRJ;
      end
      ST_D_WRJ: begin
        ram_ctrl.we    = 1'b1;
        ram_ctrl.waddr = j_q;
        ram_ctrl.wdata = s_q;
        ram_ctrl.re    = 1'b1;
        ram_ctrl.raddr = sum;
        byp_d          = (sum == j_q);
        state_d        = ST_D_OUT;
      end
      ST_D_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.result_byte     = in_q.data_byte ^ fwd_rd;
          out_d.last_of_message = in_q.end_of_message;
          out_valid_d           = 1'b1;
          state_d               = ST_IDLE;
        end
      end
      ST_K_CLR: begin
        ram_ctrl.clear = 1'b1;
        i_d            = '0;
        j_d            = '0;
        kidx_d         = '0;
        state_d        = ST_K_RD;
      end
      ST_K_RD: begin
        ram_ctrl.re    = 1'b1;
        ram_ctrl.raddr = i_q;
        byp_d          = 1'b0;
        state_d        = ST_K_J;
      end
      ST_K_J: begin
        s_d            = fwd_rd;
        j_d            = sum;
        ram_ctrl.re    = 1'b1;
        ram_ctrl.raddr = sum;
        state_d        = ST_K_WK;
      end
      ST_K_WK: begin
        ram_ctrl.we    = 1'b1;
        ram_ctrl.waddr = i_q;
        ram_ctrl.wdata = ram_rdata;
        state_d        = ST_K_WJ;
      end
      ST_K_WJ: begin
        ram_ctrl.we    = 1'b1;
        ram_ctrl.waddr = j_q;
        ram_ctrl.wdata = s_q;
        if (i_q == LAST_IDX) begin
          i_d     = '0;
          j_d     = '0;
          state_d = ST_IDLE;
        end else begin
          i_d            = sum;
          ram_ctrl.re    = 1'b1;
          ram_ctrl.raddr = sum;
          byp_d          = (sum == j_q);
          kidx_d         = (kidx_q == len_m1) ? '0 : kidx_q + KEY_IDX_W'(1);
          state_d        = ST_K_J;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      byp_q       <= 1'b0;
      kidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      byp_q       <= byp_d;
      kidx_q      <= kidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q   <= s_d;
    sj_q  <= sj_d;
    in_q  <= in_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_result_from_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_D_OUT)
    else $error("result appeared outside the output step");

  a_no_clear_with_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_ctrl.clear |-> !ram_ctrl.we)
    else $error("table clear collides with a write");

  a_rekey_starts_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.operation == OP_REKEY) |=> state_q == ST_K_CLR)
    else $error("rekey transaction did not start key scheduling");

  a_rekey_end_clears_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_K_WJ && i_q == LAST_IDX) |=> (i_q == '0 && j_q == '0 && state_q == ST_IDLE))
    else $error("indices not cleared at end of key scheduling");

endmodule

`default_nettype wire
